// ===== rtl/core/minimum_image_distance_defines.svh =====
`ifndef MINIMUM_IMAGE_DISTANCE_DEFINES_SVH
`define MINIMUM_IMAGE_DISTANCE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define MID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("minimum_image_distance: same-cycle check failed");

// Check that a condition implies another in the following cycle
`define MID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("minimum_image_distance: next-cycle check failed");

`endif

// ===== rtl/core/mid_pkg.sv =====
package mid_pkg;

    localparam int COORD_W     = 32;
    localparam int LEN_W       = 31;
    localparam int SQ_W        = 64;
    localparam int NUM_AXES    = 3;
    localparam int LANE_STAGES = 3;
    localparam int SQRT_STAGES = SQ_W / 2;
    // lanes, merge, square root; the output register comes after these
    localparam int PIPE_STAGES = LANE_STAGES + 1 + SQRT_STAGES;

    localparam logic [LEN_W-1:0] BOX_LEN_RESET = 31'd65536;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [LEN_W-1:0] t_box_len;
    typedef logic [NUM_AXES-1:0][COORD_W-1:0] t_disp_vec;
    typedef logic [NUM_AXES-1:0][SQ_W-1:0] t_sq_vec;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } t_pair;

    typedef struct packed {
        logic signed [COORD_W-1:0] disp_x;
        logic signed [COORD_W-1:0] disp_y;
        logic signed [COORD_W-1:0] disp_z;
        logic [LEN_W-1:0]          pair_distance;
    } t_result;

endpackage

// ===== rtl/core/mid_stream_if.sv =====
interface mid_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/minimum_image_distance.sv =====
// Minimum-image displacement and distance for a pair of particles in a cubic
// periodic box, signed Q16.16 in and out (the distance unsigned). One pair is
// taken every cycle while the skid register is free; a result passes through
// 3 lane stages, 1 merge stage, 32 square-root stages and the output
// register. The square-root pipeline resolves one root bit per stage. The
// whole pipeline halts only while both the output register and the skid
// register hold results, so pairs are still taken after the output stalls
// until a result moves into the skid register. The box length (reset 1.0)
// must be written over i_cfg only while no pair is in flight; the block does
// not enforce this. Displacements and the distance saturate at field limits.
`include "minimum_image_distance_defines.svh"

module minimum_image_distance #(
    parameter int DIMENSIONS = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mid_stream_if.sink   i_cfg,
    mid_stream_if.sink   i_pair,
    mid_stream_if.source o_dist
);
    import mid_pkg::*;

    t_box_len                 r_box_len;
    logic [PIPE_STAGES-1:0]   r_vld;
    logic                     s_en;
    t_disp_vec                s_first;
    t_disp_vec                s_second;
    t_disp_vec                s_lane_disp;
    t_sq_vec                  s_lane_sq;
    t_disp_vec                s_merge_disp;
    logic [SQ_W-1:0]          s_merge_sum;
    logic [SQRT_STAGES-1:0]   s_root;
    t_disp_vec                s_root_tag;
    t_result                  s_res;
    t_result                  r_out;
    logic                     r_out_vld;
    t_result                  r_skid;
    logic                     r_skid_vld;
    logic                     s_out_take;
    logic                     s_arrive;

    // Hold the box length register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_len <= BOX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_box_len <= i_cfg.data;
        end
    end

    // Advance the pipeline while the skid register is free
    assign s_en         = !r_skid_vld;
    assign i_pair.ready = s_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_en) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_pair.valid};
        end
    end

    assign s_first  = {i_pair.data.first_z, i_pair.data.first_y, i_pair.data.first_x};
    assign s_second = {i_pair.data.second_z, i_pair.data.second_y, i_pair.data.second_x};

    // One lane per active axis; unused axes contribute zero
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        if (a < DIMENSIONS) begin : g_lane
            mid_lane u_lane (
                .i_clk     (i_clk),
                .i_en      (s_en),
                .i_first   (s_first[a]),
                .i_second  (s_second[a]),
                .i_box_len (r_box_len),
                .o_disp    (s_lane_disp[a]),
                .o_sq      (s_lane_sq[a])
            );
        end else begin : g_idle
            assign s_lane_disp[a] = '0;
            assign s_lane_sq[a]   = '0;
        end
    end

    mid_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_disp (s_lane_disp),
        .i_sq   (s_lane_sq),
        .o_disp (s_merge_disp),
        .o_sum  (s_merge_sum)
    );

    mid_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_rad  (s_merge_sum),
        .i_tag  (s_merge_disp),
        .o_root (s_root),
        .o_tag  (s_root_tag)
    );

    // Assemble the result and clamp the distance to 31 bits
    always_comb begin
        s_res.disp_x        = s_root_tag[0];
        s_res.disp_y        = s_root_tag[1];
        s_res.disp_z        = s_root_tag[2];
        s_res.pair_distance = s_root[SQRT_STAGES-1] ? {LEN_W{1'b1}} : s_root[LEN_W-1:0];
    end

    // Output register with one skid entry behind it
    assign s_out_take = !r_out_vld || o_dist.ready;
    assign s_arrive   = r_vld[PIPE_STAGES-1] && s_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (s_out_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (s_arrive) begin
            if (s_out_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (s_out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (s_out_take) begin
                r_out <= r_skid;
            end
        end else if (s_arrive) begin
            if (s_out_take) begin
                r_out <= s_res;
            end else begin
                r_skid <= s_res;
            end
        end
    end

    assign o_dist.valid = r_out_vld;
    assign o_dist.data  = r_out;

    // A held skid entry always sits behind a valid output
    `MID_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, o_dist.valid)
    // A full skid entry stops intake
    `MID_ASSERT_IMP(a_skid_blocks_in, i_clk, i_rst_n, r_skid_vld, !i_pair.ready)
    // Output empties when taken with nothing behind it
    `MID_ASSERT_NXT(a_out_drains, i_clk, i_rst_n,
        o_dist.valid && o_dist.ready && !r_skid_vld && !r_vld[PIPE_STAGES-1], !o_dist.valid)

endmodule

// ===== rtl/core/mid_lane.sv =====
module mid_lane (
    input  logic             i_clk,
    input  logic             i_en,
    input  mid_pkg::t_coord  i_first,
    input  mid_pkg::t_coord  i_second,
    input  mid_pkg::t_box_len i_box_len,
    output mid_pkg::t_coord  o_disp,
    output logic [mid_pkg::SQ_W-1:0] o_sq
);
    import mid_pkg::*;

    logic [COORD_W:0]   n_here;
    logic [COORD_W+1:0] n_left;
    logic [COORD_W+1:0] n_right;
    logic [COORD_W:0]   r_here;
    logic [COORD_W+1:0] r_left;
    logic [COORD_W+1:0] r_right;

    logic [COORD_W+1:0] s_mag_l;
    logic [COORD_W+1:0] s_mag_h;
    logic [COORD_W+1:0] s_mag_r;
    logic [COORD_W+1:0] s_pick;
    logic [COORD_W-1:0] n_chosen;
    logic [COORD_W-1:0] r_chosen;

    logic [COORD_W-1:0] s_mag;
    logic [SQ_W-1:0]    n_sq;
    logic [SQ_W-1:0]    r_sq;
    logic [COORD_W-1:0] r_disp;

    // Form the direct difference and the two neighbouring images
    always_comb begin
        n_here  = {i_second[COORD_W-1], i_second} - {i_first[COORD_W-1], i_first};
        n_left  = {n_here[COORD_W], n_here} - {3'b000, i_box_len};
        n_right = {n_here[COORD_W], n_here} + {3'b000, i_box_len};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_here  <= n_here;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    // Pick the smallest magnitude; left wins any tie it is in, right only if strictly smaller than both
    always_comb begin
        s_mag_l = r_left[COORD_W+1] ? (COORD_W+2)'(-r_left) : r_left;
        s_mag_h = r_here[COORD_W] ? {1'b0, (COORD_W+1)'(-r_here)} : {1'b0, r_here};
        s_mag_r = r_right[COORD_W+1] ? (COORD_W+2)'(-r_right) : r_right;
        s_pick  = r_left;
        if (s_mag_h < s_mag_l) begin
            s_pick = {r_here[COORD_W], r_here};
        end
        if ((s_mag_r < s_mag_l) && (s_mag_r < s_mag_h)) begin
            s_pick = r_right;
        end
        // saturate to 32 bits signed
        if ((s_pick[COORD_W+1:COORD_W-1] == 3'b000) ||
            (s_pick[COORD_W+1:COORD_W-1] == 3'b111)) begin
            n_chosen = s_pick[COORD_W-1:0];
        end else if (s_pick[COORD_W+1]) begin
            n_chosen = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            n_chosen = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chosen <= n_chosen;
        end
    end

    // Square the magnitude of the chosen component
    always_comb begin
        s_mag = r_chosen[COORD_W-1] ? COORD_W'(-r_chosen) : r_chosen;
        n_sq  = SQ_W'(s_mag) * SQ_W'(s_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_disp <= r_chosen;
        end
    end

    assign o_disp = r_disp;
    assign o_sq   = r_sq;

endmodule

// ===== rtl/core/mid_merge.sv =====
module mid_merge (
    input  logic               i_clk,
    input  logic               i_en,
    input  mid_pkg::t_disp_vec i_disp,
    input  mid_pkg::t_sq_vec   i_sq,
    output mid_pkg::t_disp_vec o_disp,
    output logic [mid_pkg::SQ_W-1:0] o_sum
);
    import mid_pkg::*;

    logic [SQ_W-1:0] n_sum;
    logic [SQ_W-1:0] r_sum;
    t_disp_vec       r_disp;

    // Add the lane squares; three squares of at most 2^62 fit in 64 bits
    always_comb begin
        n_sum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_sum = n_sum + i_sq[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_disp <= i_disp;
        end
    end

    assign o_sum  = r_sum;
    assign o_disp = r_disp;

endmodule

// ===== rtl/core/mid_isqrt.sv =====
module mid_isqrt (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [mid_pkg::SQ_W-1:0] i_rad,
    input  mid_pkg::t_disp_vec i_tag,
    output logic [mid_pkg::SQRT_STAGES-1:0] o_root,
    output mid_pkg::t_disp_vec o_tag
);
    import mid_pkg::*;

    localparam int ROOT_W = SQRT_STAGES;
    localparam int REM_W  = ROOT_W + 1;

    logic [REM_W-1:0]  s_rem_in  [SQRT_STAGES];
    logic [ROOT_W-1:0] s_root_in [SQRT_STAGES];
    logic [SQ_W-1:0]   s_rad_in  [SQRT_STAGES];
    t_disp_vec         s_tag_in  [SQRT_STAGES];

    logic [REM_W-1:0]  r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];
    logic [SQ_W-1:0]   r_rad  [SQRT_STAGES];
    t_disp_vec         r_tag  [SQRT_STAGES];

    assign s_rem_in[0]  = '0;
    assign s_root_in[0] = '0;
    assign s_rad_in[0]  = i_rad;
    assign s_tag_in[0]  = i_tag;

    // One root bit per stage, restoring method, two radicand bits consumed
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        logic [REM_W+1:0] s_rem_sh;
        logic [REM_W+1:0] s_trial;
        logic [REM_W+1:0] s_diff;
        logic             s_fit;

        if (k > 0) begin : g_link
            assign s_rem_in[k]  = r_rem[k-1];
            assign s_root_in[k] = r_root[k-1];
            assign s_rad_in[k]  = r_rad[k-1];
            assign s_tag_in[k]  = r_tag[k-1];
        end

        assign s_rem_sh = {s_rem_in[k], s_rad_in[k][SQ_W-1-2*k -: 2]};
        assign s_trial  = {1'b0, s_root_in[k], 2'b01};
        assign s_fit    = (s_rem_sh >= s_trial);
        assign s_diff   = s_rem_sh - s_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= s_fit ? s_diff[REM_W-1:0] : s_rem_sh[REM_W-1:0];
                r_root[k] <= {s_root_in[k][ROOT_W-2:0], s_fit};
                r_rad[k]  <= s_rad_in[k];
                r_tag[k]  <= s_tag_in[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];
    assign o_tag  = r_tag[SQRT_STAGES-1];

endmodule
